// ===== sv/ebs_pkg.sv =====
// ebs_pkg: shared types, codes and helpers of the eeprom burst sequencer
// depends on nothing; imported by every module of the block
package ebs_pkg;

  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_STOP      = 3'd1,
    ACT_SEND      = 3'd2,
    ACT_RECV_ACK  = 3'd3,
    ACT_RECV_NACK = 3'd4,
    ACT_WAIT      = 3'd5
  } bus_action_t;

  typedef enum logic [1:0] {
    CFG_WRITE_CODE = 2'd0,
    CFG_READ_CODE  = 2'd1,
    CFG_PAGE_BITS  = 2'd2,
    CFG_WAIT_COUNT = 2'd3
  } cfg_index_t;

  localparam int NUM_SLOTS   = 9;
  localparam int SLOT_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [SLOT_W-1:0] SLOT_START    = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_WCODE    = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_HI  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_ADDR_LO  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_RESTART  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_RCODE    = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_DATA     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_STOP     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_WAIT     = 4'd8;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic [7:0] write_code;
    logic [7:0] read_code;
    logic [3:0] page_bits;
    logic [7:0] wait_count;
  } cfg_t;

  typedef struct packed {
    slot_mask_t  slots;
    bus_action_t data_act;
    logic [15:0] addr;
    logic [7:0]  data;
  } desc_t;

  function automatic logic [15:0] page_mask(input logic [3:0] pb);
    logic [16:0] full;
    full = (17'd1 << pb) - 17'd1;
    page_mask = full[15:0];
  endfunction

endpackage

// ===== sv/eeprom_burst_sequencer.sv =====
// eeprom_burst_sequencer: top level, configuration registers and the front, queue, back chain
// depends on ebs_pkg, ebs_front, ebs_queue, ebs_back
//
// usage
//   in_*  : one word per eeprom byte item; tlast closes the burst, tuser carries
//           the command and the burst-open flag
//   out_* : one word per i2c bus action; tuser carries the action code, tdata the
//           byte, tlast marks the last action of an item
//   cfg_* : register writes, taken at any edge with cfg_we high; write only while idle
// an item taken is registered in the descriptor queue before its first action word
//   is registered at the output
// throughput: the back end emits one action per cycle while out_tready is high;
//   an item has 1 to 8 actions; the front takes a word per cycle
//   while the four-entry descriptor queue has room
// an item outside an open burst produces no actions and is dropped at the front
// reset clears burst state, the queue and the output valid flag, and loads the
//   default device codes, page size and wait count
// when the receiver stalls the output word holds, the queue fills and in_tready
//   falls once four descriptors wait
module eeprom_burst_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // mem_address[15:0], write_data[23:16]
  input  logic [1:0]  in_tuser,   // command[0], first_item[1]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // action_byte[7:0]
  output logic [2:0]  out_tuser,  // bus_action[2:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import ebs_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  desc_t       push_desc;
  desc_t       head;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  bus_action_t out_action;
  logic [7:0]  out_byte;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_WRITE_CODE: cfg_nxt.write_code = cfg_wdata;
        CFG_READ_CODE:  cfg_nxt.read_code  = cfg_wdata;
        CFG_PAGE_BITS:  cfg_nxt.page_bits  = cfg_wdata[3:0];
        CFG_WAIT_COUNT: cfg_nxt.wait_count = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.write_code <= 8'hA0;
      cfg_r.read_code  <= 8'hA1;
      cfg_r.page_bits  <= 4'd6;
      cfg_r.wait_count <= 8'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ebs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .command     (in_tuser[0]),
    .mem_address (in_tdata[15:0]),
    .write_data  (in_tdata[23:16]),
    .first_item  (in_tuser[1]),
    .last_item   (in_tlast),
    .cfg         (cfg_r),
    .queue_full  (full),
    .push        (push),
    .desc        (push_desc)
  );

  ebs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  ebs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_action (out_action),
    .out_byte   (out_byte),
    .out_end    (out_tlast)
  );

  assign out_tdata = out_byte;
  assign out_tuser = out_action;

endmodule

// ===== sv/ebs_front.sv =====
// ebs_front: accepts words, tracks burst state and turns each word of an open burst into a descriptor
// depends on ebs_pkg
module ebs_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          command,
  input  logic [15:0]   mem_address,
  input  logic [7:0]    write_data,
  input  logic          first_item,
  input  logic          last_item,
  input  ebs_pkg::cfg_t cfg,
  input  logic          queue_full,
  output logic          push,
  output ebs_pkg::desc_t desc
);
  import ebs_pkg::*;

  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic        is_read_r, is_read_nxt;
  logic        open_r, open_nxt;

  logic        accept;
  logic        eff_read;
  logic [15:0] base_addr;
  logic [15:0] next_addr;
  logic [15:0] pmask;
  logic        produce;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pmask     = page_mask(cfg.page_bits);
    eff_read  = first_item ? command : is_read_r;
    base_addr = first_item ? mem_address : cur_addr_r;
    next_addr = base_addr + 16'd1;
    produce   = first_item || open_r;

    desc.slots    = '0;
    desc.data_act = ACT_SEND;
    desc.addr     = base_addr;
    desc.data     = write_data;

    cur_addr_nxt = cur_addr_r;
    is_read_nxt  = is_read_r;
    open_nxt     = open_r;

    if (first_item) begin
      desc.slots[SLOT_START]   = 1'b1;
      desc.slots[SLOT_WCODE]   = 1'b1;
      desc.slots[SLOT_ADDR_HI] = 1'b1;
      desc.slots[SLOT_ADDR_LO] = 1'b1;
      desc.slots[SLOT_RESTART] = command;
      desc.slots[SLOT_RCODE]   = command;
    end else if (!eff_read && (base_addr & pmask) == 16'd0) begin
      desc.slots[SLOT_START]   = 1'b1;
      desc.slots[SLOT_WCODE]   = 1'b1;
      desc.slots[SLOT_ADDR_HI] = 1'b1;
      desc.slots[SLOT_ADDR_LO] = 1'b1;
    end

    desc.slots[SLOT_DATA] = 1'b1;
    if (eff_read) begin
      desc.data_act = last_item ? ACT_RECV_NACK : ACT_RECV_ACK;
      desc.slots[SLOT_STOP] = last_item;
    end else begin
      if (last_item || (next_addr & pmask) == 16'd0) begin
        desc.slots[SLOT_STOP] = 1'b1;
        desc.slots[SLOT_WAIT] = 1'b1;
      end
    end

    push = accept && produce;

    if (push) begin
      open_nxt    = !last_item;
      is_read_nxt = eff_read;
      if (first_item) begin
        cur_addr_nxt = mem_address;
      end
      if (!eff_read) begin
        cur_addr_nxt = next_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_addr_r <= '0;
      is_read_r  <= 1'b0;
      open_r     <= 1'b0;
    end else begin
      cur_addr_r <= cur_addr_nxt;
      is_read_r  <= is_read_nxt;
      open_r     <= open_nxt;
    end
  end

endmodule

// ===== sv/ebs_queue.sv =====
// ebs_queue: short descriptor queue between front and back
// depends on ebs_pkg
module ebs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ebs_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output ebs_pkg::desc_t head,
  output logic           empty
);
  import ebs_pkg::*;

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== sv/ebs_back.sv =====
// ebs_back: walks the slots of the head descriptor, one bus action per cycle unless the output stalls
// depends on ebs_pkg; drives the registered result channel
module ebs_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ebs_pkg::desc_t head,
  input  logic           empty,
  output logic           pop,
  input  ebs_pkg::cfg_t  cfg,
  output logic           out_valid,
  input  logic           out_ready,
  output ebs_pkg::bus_action_t out_action,
  output logic [7:0]     out_byte,
  output logic           out_end
);
  import ebs_pkg::*;

  slot_mask_t        done_r, done_nxt;
  logic              valid_r, valid_nxt;
  bus_action_t       action_r, action_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              end_r, end_nxt;

  slot_mask_t        rem;
  slot_mask_t        sel;
  slot_mask_t        rest;
  logic              advance;
  logic [SLOT_W-1:0] slot_idx;

  always_comb begin
    rem      = head.slots & ~done_r;
    sel      = rem & (~rem + 1'b1);
    rest     = rem & ~sel;
    advance  = !empty && (!valid_r || out_ready);
    slot_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        slot_idx = SLOT_W'(i);
      end
    end

    case (slot_idx)
      SLOT_START, SLOT_RESTART: begin
        action_nxt = ACT_START;
        byte_nxt   = 8'd0;
      end
      SLOT_WCODE: begin
        action_nxt = ACT_SEND;
        byte_nxt   = cfg.write_code;
      end
      SLOT_ADDR_HI: begin
        action_nxt = ACT_SEND;
        byte_nxt   = head.addr[15:8];
      end
      SLOT_ADDR_LO: begin
        action_nxt = ACT_SEND;
        byte_nxt   = head.addr[7:0];
      end
      SLOT_RCODE: begin
        action_nxt = ACT_SEND;
        byte_nxt   = cfg.read_code;
      end
      SLOT_DATA: begin
        action_nxt = head.data_act;
        byte_nxt   = (head.data_act == ACT_SEND) ? head.data : 8'd0;
      end
      SLOT_STOP: begin
        action_nxt = ACT_STOP;
        byte_nxt   = 8'd0;
      end
      SLOT_WAIT: begin
        action_nxt = ACT_WAIT;
        byte_nxt   = cfg.wait_count;
      end
      default: begin
        action_nxt = ACT_START;
        byte_nxt   = 8'd0;
      end
    endcase
    end_nxt = (rest == '0);

    pop = advance && (rest == '0);

    done_nxt = done_r;
    if (advance) begin
      done_nxt = (rest == '0) ? '0 : (done_r | sel);
    end

    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      done_r  <= done_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      action_r <= action_nxt;
      byte_r   <= byte_nxt;
      end_r    <= end_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_action = action_r;
  assign out_byte   = byte_r;
  assign out_end    = end_r;

endmodule

// ===== sv/ebs_checker.sv =====
// ebs_checker: port-level assertions on the eeprom burst sequencer, bound to the top level
// depends on ebs_pkg and eeprom_burst_sequencer
module ebs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import ebs_pkg::*;

  logic [2:0] act;
  assign act = out_tuser;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) &&
    $stable(out_tlast))
    else $error("stalled result word changed");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> act <= ACT_WAIT)
    else $error("bus action code out of range");

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (act == ACT_START || act == ACT_STOP || act == ACT_RECV_ACK ||
                   act == ACT_RECV_NACK) |-> out_tdata == 8'd0)
    else $error("non-data action carries a byte");

  a_wait_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && act == ACT_WAIT |-> out_tlast)
    else $error("wait action not last of its item");

endmodule

bind eeprom_burst_sequencer ebs_checker u_ebs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== bench/eeprom_burst_sequencer_tb.sv =====
`timescale 1ns / 1ps
// eeprom_burst_sequencer_tb: self-checking bench for the eeprom burst sequencer
// drives byte words and register writes, predicts each bus action word and
// compares the output stream with it; depends on ebs_pkg and the rtl top level
module eeprom_burst_sequencer_tb;
  import ebs_pkg::*;

  typedef struct {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        first;
    logic        last;
  } byte_item_t;

  typedef struct {
    bus_action_t act;
    logic [7:0]  abyte;
    logic        run_end;
  } bus_word_t;

  typedef struct {
    byte_item_t  it;
    int          n_typed;
    logic [87:0] typed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // mem_address[15:0], write_data[23:16]
  logic [1:0]  in_tuser = '0;   // command[0], first_item[1]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // action_byte[7:0]
  logic [2:0]  out_tuser;       // bus_action[2:0]
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  logic [7:0]  seq_wcode, seq_rcode, seq_wait;
  logic [3:0]  seq_pbits;
  logic [15:0] seq_addr;
  logic        seq_read, seq_open;

  bus_word_t   due_actions[$];
  bus_word_t   step_actions[$];
  stim_row_t   stim_rows[$];
  int          errors = 0;
  bit          quiet = 1'b0;

  eeprom_burst_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [10:0] ac(bus_action_t a, logic [7:0] b);
    return {a, b};
  endfunction

  function automatic logic [15:0] page_low_mask(logic [3:0] pb);
    return 16'hFFFF >> (16 - pb);
  endfunction

  function automatic void add_action(bus_action_t a, logic [7:0] b);
    bus_word_t w;
    w.act = a;
    w.abyte = b;
    w.run_end = 1'b0;
    step_actions.push_back(w);
  endfunction

  function automatic void add_header();
    add_action(ACT_START, 8'h00);
    add_action(ACT_SEND, seq_wcode);
    add_action(ACT_SEND, seq_addr[15:8]);
    add_action(ACT_SEND, seq_addr[7:0]);
  endfunction

  function automatic void plan_actions(byte_item_t it);
    logic [15:0] pmask;
    pmask = page_low_mask(seq_pbits);
    step_actions.delete();
    if (it.first) begin
      seq_open = 1'b1;
      seq_read = it.cmd;
      seq_addr = it.addr;
      add_header();
      if (seq_read) begin
        add_action(ACT_START, 8'h00);
        add_action(ACT_SEND, seq_rcode);
      end
    end else if (!seq_open) begin
      return;
    end else if (!seq_read && (seq_addr & pmask) == 16'h0000) begin
      add_header();
    end
    if (seq_read) begin
      if (it.last) begin
        add_action(ACT_RECV_NACK, 8'h00);
        add_action(ACT_STOP, 8'h00);
        seq_open = 1'b0;
      end else begin
        add_action(ACT_RECV_ACK, 8'h00);
      end
    end else begin
      add_action(ACT_SEND, it.data);
      seq_addr = seq_addr + 16'd1;
      if (it.last || (seq_addr & pmask) == 16'h0000) begin
        add_action(ACT_STOP, 8'h00);
        add_action(ACT_WAIT, seq_wait);
        if (it.last) seq_open = 1'b0;
      end
    end
    step_actions[step_actions.size() - 1].run_end = 1'b1;
  endfunction

  function automatic int pick_gap(bit sender);
    int r;
    if (quiet) return sender ? 0 : 1;
    r = $urandom_range(0, 19);
    if (sender && r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_item_t rand_item();
    byte_item_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.addr = 16'($urandom_range(0, 16'hFFFF));
    it.data = 8'($urandom_range(0, 8'hFF));
    it.first = 1'b0;
    it.last = 1'b0;
    return it;
  endfunction

  function automatic void add_row(logic cmd, logic [15:0] addr, logic [7:0] data,
                                  logic first, logic last, int n, logic [87:0] typed);
    stim_row_t r;
    r.it.cmd = cmd;
    r.it.addr = addr;
    r.it.data = data;
    r.it.first = first;
    r.it.last = last;
    r.n_typed = n;
    r.typed = typed;
    stim_rows.push_back(r);
  endfunction

  task automatic wait_drained();
    while (due_actions.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(byte_item_t it, int n_typed, logic [87:0] typed);
    int gap;
    int k;
    bus_word_t w;
    gap = pick_gap(1'b1);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.data, it.addr};
    in_tuser <= {it.first, it.cmd};
    in_tlast <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    plan_actions(it);
    if (n_typed >= 0) begin
      for (k = 0; k < n_typed; k++) begin
        w.act = bus_action_t'(typed[(n_typed - 1 - k) * 11 + 8 +: 3]);
        w.abyte = typed[(n_typed - 1 - k) * 11 +: 8];
        w.run_end = (k == n_typed - 1);
        due_actions.push_back(w);
      end
    end else begin
      foreach (step_actions[i]) due_actions.push_back(step_actions[i]);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] wc, input logic [7:0] rc,
                            input logic [3:0] pb, input logic [7:0] wt);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WRITE_CODE;
    cfg_wdata <= wc;
    @(posedge clk);
    cfg_index <= CFG_READ_CODE;
    cfg_wdata <= rc;
    @(posedge clk);
    cfg_index <= CFG_PAGE_BITS;
    cfg_wdata <= {4'($urandom_range(0, 15)), pb};
    @(posedge clk);
    cfg_index <= CFG_WAIT_COUNT;
    cfg_wdata <= wt;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_wcode = wc;
    seq_rcode = rc;
    seq_pbits = pb;
    seq_wait = wt;
  endtask

  task automatic run_phase(int n_items);
    int count, len, kind, k;
    bit paused;
    byte_item_t it;
    logic [15:0] pmask;
    count = 0;
    paused = 1'b0;
    while (count < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        // stray word, ignored unless a burst was left open
        it = rand_item();
        it.last = 1'($urandom_range(0, 1));
        send_item(it, -1, '0);
      end else begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        it = rand_item();
        it.first = 1'b1;
        pmask = page_low_mask(seq_pbits);
        case ($urandom_range(0, 3))
          0: it.addr = (it.addr | pmask) - 16'($urandom_range(0, 3));
          1: it.addr = 16'hFFFF - 16'($urandom_range(0, 3));
          default: ;
        endcase
        for (k = 0; k < len; k++) begin
          if (k > 0) it = rand_item();
          // kind 8 leaves the burst open so the next one abandons it
          it.last = (k == len - 1) && (kind != 8);
          send_item(it, -1, '0);
          count++;
        end
      end
      if (!paused && count >= n_items / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    bus_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_actions.size() == 0) begin
        $error("unexpected bus action word %0d byte %h last %b", out_tuser, out_tdata,
               out_tlast);
        errors++;
      end else begin
        w = due_actions.pop_front();
        if (out_tuser !== w.act) begin
          $error("bus_action: expected %0d, actual %0d", w.act, out_tuser);
          errors++;
        end
        if (out_tdata !== w.abyte) begin
          $error("action_byte: expected %h, actual %h", w.abyte, out_tdata);
          errors++;
        end
        if (out_tlast !== w.run_end) begin
          $error("run_end: expected %b, actual %b", w.run_end, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet) begin
        gap = pick_gap(1'b0);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    seq_wcode = 8'hA0;
    seq_rcode = 8'hA1;
    seq_pbits = 4'd6;
    seq_wait = 8'd100;
    seq_addr = 16'h0000;
    seq_read = 1'b0;
    seq_open = 1'b0;

    // word outside any burst
    add_row(1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 0, '0);
    add_row(1'b0, 16'h1234, 8'h00, 1'b1, 1'b0, 5,
            88'({ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA0), ac(ACT_SEND, 8'h12),
                 ac(ACT_SEND, 8'h34), ac(ACT_SEND, 8'h00)}));
    add_row(1'b0, 16'hFFFF, 8'hFF, 1'b0, 1'b1, 3,
            88'({ac(ACT_SEND, 8'hFF), ac(ACT_STOP, 8'h00), ac(ACT_WAIT, 8'd100)}));
    // page crossing in the middle of a burst
    add_row(1'b0, 16'h003F, 8'hA5, 1'b1, 1'b0, 7,
            88'({ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA0), ac(ACT_SEND, 8'h00),
                 ac(ACT_SEND, 8'h3F), ac(ACT_SEND, 8'hA5), ac(ACT_STOP, 8'h00),
                 ac(ACT_WAIT, 8'd100)}));
    add_row(1'b1, 16'h0000, 8'h5A, 1'b0, 1'b0, -1, '0);
    add_row(1'b0, 16'h0000, 8'h01, 1'b0, 1'b1, -1, '0);
    add_row(1'b1, 16'hFFFF, 8'h00, 1'b1, 1'b0, 7,
            88'({ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA0), ac(ACT_SEND, 8'hFF),
                 ac(ACT_SEND, 8'hFF), ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA1),
                 ac(ACT_RECV_ACK, 8'h00)}));
    add_row(1'b0, 16'h1234, 8'hC3, 1'b0, 1'b0, -1, '0);
    add_row(1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 2,
            88'({ac(ACT_RECV_NACK, 8'h00), ac(ACT_STOP, 8'h00)}));
    add_row(1'b1, 16'h0000, 8'hFF, 1'b1, 1'b1, 8,
            {ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA0), ac(ACT_SEND, 8'h00),
             ac(ACT_SEND, 8'h00), ac(ACT_START, 8'h00), ac(ACT_SEND, 8'hA1),
             ac(ACT_RECV_NACK, 8'h00), ac(ACT_STOP, 8'h00)});
    // address wraps at the top of memory
    add_row(1'b0, 16'hFFFF, 8'h80, 1'b1, 1'b0, -1, '0);
    add_row(1'b1, 16'h1111, 8'h7F, 1'b0, 1'b1, -1, '0);
    // new bursts over open ones
    add_row(1'b0, 16'h0100, 8'h11, 1'b1, 1'b0, -1, '0);
    add_row(1'b1, 16'h8000, 8'h00, 1'b1, 1'b0, -1, '0);
    add_row(1'b0, 16'h7FFE, 8'h22, 1'b1, 1'b0, -1, '0);
    add_row(1'b0, 16'h0000, 8'h33, 1'b0, 1'b0, -1, '0);
    add_row(1'b0, 16'h0000, 8'h44, 1'b0, 1'b1, -1, '0);
    add_row(1'b1, 16'h0000, 8'h00, 1'b0, 1'b0, -1, '0);
    add_row(1'b0, 16'hAAAA, 8'hC3, 1'b1, 1'b1, -1, '0);
    add_row(1'b0, 16'h5555, 8'h3C, 1'b1, 1'b0, -1, '0);
    add_row(1'b1, 16'h5556, 8'h00, 1'b1, 1'b1, -1, '0);
    add_row(1'b0, 16'h0000, 8'h99, 1'b0, 1'b0, -1, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_item(stim_rows[i].it, stim_rows[i].n_typed, stim_rows[i].typed);
    settle();

    write_regs(8'h00, 8'hFF, 4'd0, 8'hFF);
    run_phase(30);
    settle();
    quiet = 1'b1;
    write_regs(8'hFF, 8'h00, 4'd8, 8'h00);
    run_phase(30);
    settle();
    quiet = 1'b0;
    write_regs(8'hA0, 8'hA1, 4'd15, 8'd100);
    run_phase(30);
    settle();
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               4'($urandom_range(1, 5)), 8'($urandom_range(0, 255)));
    run_phase(30);
    settle();
    write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 4'd9,
               8'($urandom_range(0, 255)));
    run_phase(30);
    settle();
    write_regs(8'hA0, 8'hA1, 4'd3, 8'h0A);
    run_phase(30);
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
